// ----- hdl/vnm_pkg.sv -----
// ============================================================================
// vnm_pkg
// Shared constants for the vector normalizer with magnitude.
// ============================================================================
package vnm_pkg;

    // Width of every component word and every result component word.
    localparam int FIELD_W          = 32;
    // Width of the magnitude result word.
    localparam int LEN_W            = 32;
    // Default number of component bits that are used, two's complement.
    localparam int COMPONENT_WIDTH  = 32;
    // Fraction bits of the components and of the magnitude.
    localparam int FRACTION_BITS    = 16;
    // Fraction bits of the unit vector components.
    localparam int UNIT_FRAC        = 30;

    // The unit component is round(sqrt(Q)) with Q = c^2 * 2^(2*UNIT_FRAC+2) / S.
    // Q never exceeds 2^(2*UNIT_FRAC+2), so it needs this many bits.
    localparam int QUO_W            = 2 * UNIT_FRAC + 3;
    // Radicand width for the root of Q, rounded up to an even count.
    localparam int QRAD_W           = QUO_W + (QUO_W % 2);
    // Root width of Q.
    localparam int QROOT_W          = QRAD_W / 2;

endpackage

// ----- hdl/vnm_if.sv -----
// ============================================================================
// vnm_in_if / vnm_out_if
// Valid/ready channels for the vector words and the result words.
// ============================================================================
interface vnm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [vnm_pkg::FIELD_W-1:0]  vec_x;
    logic signed [vnm_pkg::FIELD_W-1:0]  vec_y;
    logic signed [vnm_pkg::FIELD_W-1:0]  vec_z;

    modport source (output valid, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface vnm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [vnm_pkg::FIELD_W-1:0]  unit_x;
    logic signed [vnm_pkg::FIELD_W-1:0]  unit_y;
    logic signed [vnm_pkg::FIELD_W-1:0]  unit_z;
    logic        [vnm_pkg::LEN_W-1:0]    length;
    logic                                was_zero;

    modport source (output valid, unit_x, unit_y, unit_z, length, was_zero, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, length, was_zero, output ready);
endinterface

// ----- hdl/vnm_sqrt_cell.sv -----
// ============================================================================
// vnm_sqrt_cell
// One digit step of a restoring integer square root, with a sideband.
// ============================================================================
module vnm_sqrt_cell #(
    parameter int NW  = 66,
    parameter int SBW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NW-1:0]        i_rad,
    input  logic [NW/2+1:0]      i_rem,
    input  logic [NW/2-1:0]      i_root,
    input  logic [SBW-1:0]       i_sb,
    output logic                 o_valid,
    output logic [NW-1:0]        o_rad,
    output logic [NW/2+1:0]      o_rem,
    output logic [NW/2-1:0]      o_root,
    output logic [SBW-1:0]       o_sb
);
    localparam int K = NW / 2;

    logic [K+3:0]  w_sh;
    logic [K+3:0]  w_trial;
    logic [K+3:0]  w_diff;
    logic          w_ge;
    logic [NW-1:0] n_rad;
    logic [K+1:0]  n_rem;
    logic [K-1:0]  n_root;

    logic          r_valid;
    logic [NW-1:0] r_rad;
    logic [K+1:0]  r_rem;
    logic [K-1:0]  r_root;
    logic [SBW-1:0] r_sb;

    // Bring down the next two radicand bits and try the digit one.
    always_comb begin
        w_sh    = {i_rem, i_rad[NW-1:NW-2]};
        w_trial = (K+4)'({i_root, 2'b01});
        w_ge    = (w_sh >= w_trial);
        w_diff  = w_sh - w_trial;
        n_rem   = w_ge ? w_diff[K+1:0] : w_sh[K+1:0];
        n_root  = {i_root[K-2:0], w_ge};
        n_rad   = {i_rad[NW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_sb   <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_sb    = r_sb;
endmodule

// ----- hdl/vnm_div_cell.sv -----
// ============================================================================
// vnm_div_cell
// One quotient bit of a restoring divider, with a sideband.
// ============================================================================
module vnm_div_cell #(
    parameter int DW  = 66,
    parameter int QW  = 63,
    parameter int SBW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [DW-1:0]   i_dvs,
    input  logic [DW-1:0]   i_rem,
    input  logic            i_nbit,
    input  logic [QW-1:0]   i_quo,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_valid,
    output logic [DW-1:0]   o_dvs,
    output logic [DW-1:0]   o_rem,
    output logic            o_nbit,
    output logic [QW-1:0]   o_quo,
    output logic [SBW-1:0]  o_sb
);
    logic [DW:0]    w_t;
    logic [DW:0]    w_diff;
    logic           w_ge;
    logic [DW-1:0]  n_rem;
    logic [QW-1:0]  n_quo;

    logic           r_valid;
    logic [DW-1:0]  r_dvs;
    logic [DW-1:0]  r_rem;
    logic [QW-1:0]  r_quo;
    logic [SBW-1:0] r_sb;

    always_comb begin
        w_t    = {i_rem, i_nbit};
        w_ge   = (w_t >= {1'b0, i_dvs});
        w_diff = w_t - {1'b0, i_dvs};
        n_rem  = w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
        n_quo  = {i_quo[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvs <= i_dvs;
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_sb  <= i_sb;
        end
    end

    // Only the first cell sees a nonzero dividend bit; the rest of the
    // dividend is all zeros.
    assign o_nbit  = 1'b0;
    assign o_valid = r_valid;
    assign o_dvs   = r_dvs;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_sb    = r_sb;
endmodule

// ----- hdl/vector_normalize_with_magnitude_top.sv -----
// ============================================================================
// vector_normalize_with_magnitude_top
// Normalizes a 3D fixed-point vector and returns its rounded magnitude.
// ============================================================================
// This block accepts one vector word per clock whenever the pipeline
// advances and returns one result word per vector, in order. Each vector
// passes through a fixed pipeline of 3 + (COMPONENT_WIDTH+1) + 1 +
// (2*UNIT_FRAC+3) + 32 + 1 stages: three front stages take absolute values,
// square the components and add the squares; a row of square root cells
// forms the magnitude one bit per cell; one stage rounds it; three rows of
// divider cells, one per component, form c^2 * 2^62 / S one quotient bit per
// cell; three rows of square root cells take the root of that quotient; and
// the last stage rounds, applies the sign and fills the output register.
// The whole pipeline advances together whenever the output register is
// empty or its word is being taken, so the input ready follows the output
// ready and no bubbles are needed between vectors. A zero vector gives the
// unit vector (1.0, 0, 0), magnitude 1.0 and the zero flag. The magnitude
// saturates to all ones if it ever exceeds 32 bits.
// ============================================================================
module vector_normalize_with_magnitude_top #(
    parameter int COMPONENT_WIDTH = vnm_pkg::COMPONENT_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vnm_in_if.sink       i_vec,
    vnm_out_if.source    o_res
);
    // Magnitude of a component fits in COMPONENT_WIDTH bits, even for the
    // most negative value.
    localparam int W    = COMPONENT_WIDTH;
    localparam int SQW  = 2 * W;
    localparam int SW   = 2 * W + 2;
    localparam int RK   = SW / 2;
    localparam int LFW  = (RK + 1 > vnm_pkg::LEN_W) ? RK + 1 : vnm_pkg::LEN_W;
    localparam int SBA  = SW + 3 * SQW + 4;
    localparam int SBX  = 2 + vnm_pkg::LEN_W;
    localparam int QW   = vnm_pkg::QUO_W;
    localparam int QNW  = vnm_pkg::QRAD_W;
    localparam int QK   = vnm_pkg::QROOT_W;
    localparam int FW   = vnm_pkg::FIELD_W;

    logic w_en;

    // The pipeline moves as one; the output register is the last stage.
    logic r_o_valid;
    assign w_en        = !r_o_valid || o_res.ready;
    assign i_vec.ready = w_en;

    // ------------------------------------------------------------------
    // Front stages: absolute values, squares, sum of squares.
    // ------------------------------------------------------------------
    logic [W-1:0]   w_raw [0:2];
    logic [W-1:0]   n0_mag [0:2];
    logic [2:0]     n0_neg;

    logic           r0_valid;
    logic [W-1:0]   r0_mag [0:2];
    logic [2:0]     r0_neg;
    logic           r0_zero;
    logic           r1_valid;
    logic [SQW-1:0] r1_sq [0:2];
    logic [2:0]     r1_neg;
    logic           r1_zero;
    logic           r2_valid;
    logic [SW-1:0]  r2_s;
    logic [SQW-1:0] r2_sq [0:2];
    logic [2:0]     r2_neg;
    logic           r2_zero;

    always_comb begin
        w_raw[0] = W'($unsigned(i_vec.vec_x));
        w_raw[1] = W'($unsigned(i_vec.vec_y));
        w_raw[2] = W'($unsigned(i_vec.vec_z));
        for (int i = 0; i < 3; i++) begin
            n0_neg[i] = w_raw[i][W-1];
            n0_mag[i] = n0_neg[i] ? (~w_raw[i] + W'(1)) : w_raw[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_vec.valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r0_mag[i] <= n0_mag[i];
                r1_sq[i]  <= SQW'(r0_mag[i]) * SQW'(r0_mag[i]);
                r2_sq[i]  <= r1_sq[i];
            end
            r0_neg  <= n0_neg;
            r0_zero <= (n0_mag[0] == '0) && (n0_mag[1] == '0) && (n0_mag[2] == '0);
            r1_neg  <= r0_neg;
            r1_zero <= r0_zero;
            r2_s    <= SW'(r1_sq[0]) + SW'(r1_sq[1]) + SW'(r1_sq[2]);
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
        end
    end

    // ------------------------------------------------------------------
    // Magnitude: row of square root cells over S.
    // ------------------------------------------------------------------
    logic            wa_valid [0:RK];
    logic [SW-1:0]   wa_rad   [0:RK];
    logic [RK+1:0]   wa_rem   [0:RK];
    logic [RK-1:0]   wa_root  [0:RK];
    logic [SBA-1:0]  wa_sb    [0:RK];

    assign wa_valid[0] = r2_valid;
    assign wa_rad[0]   = r2_s;
    assign wa_rem[0]   = '0;
    assign wa_root[0]  = '0;
    assign wa_sb[0]    = {r2_s, r2_sq[0], r2_sq[1], r2_sq[2], r2_neg, r2_zero};

    for (genvar g = 0; g < RK; g++) begin : g_mag
        vnm_sqrt_cell #(.NW(SW), .SBW(SBA)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (wa_valid[g]),
            .i_rad   (wa_rad[g]),
            .i_rem   (wa_rem[g]),
            .i_root  (wa_root[g]),
            .i_sb    (wa_sb[g]),
            .o_valid (wa_valid[g+1]),
            .o_rad   (wa_rad[g+1]),
            .o_rem   (wa_rem[g+1]),
            .o_root  (wa_root[g+1]),
            .o_sb    (wa_sb[g+1])
        );
    end

    // Round to nearest: step up when the remainder S - r^2 exceeds r.
    logic [SW-1:0]            wl_s;
    logic [SQW-1:0]           wl_sq [0:2];
    logic [2:0]               wl_neg;
    logic                     wl_zero;
    logic                     wl_up;
    logic [RK:0]              wl_full;
    logic [LFW-1:0]           wl_ext;
    logic [vnm_pkg::LEN_W-1:0] nl_len;

    always_comb begin
        {wl_s, wl_sq[0], wl_sq[1], wl_sq[2], wl_neg, wl_zero} = wa_sb[RK];
        wl_up   = (wa_rem[RK] > (RK+2)'(wa_root[RK]));
        wl_full = (RK+1)'(wa_root[RK]) + (RK+1)'(wl_up);
        wl_ext  = LFW'(wl_full);
        nl_len  = (wl_ext > LFW'({vnm_pkg::LEN_W{1'b1}})) ? '1 : wl_ext[vnm_pkg::LEN_W-1:0];
    end

    logic                      rl_valid;
    logic [SW-1:0]             rl_s;
    logic [SQW-1:0]            rl_sq [0:2];
    logic [2:0]                rl_neg;
    logic                      rl_zero;
    logic [vnm_pkg::LEN_W-1:0] rl_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rl_valid <= 1'b0;
        end else if (w_en) begin
            rl_valid <= wa_valid[RK];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rl_s    <= wl_s;
            rl_sq   <= wl_sq;
            rl_neg  <= wl_neg;
            rl_zero <= wl_zero;
            rl_len  <= nl_len;
        end
    end

    // ------------------------------------------------------------------
    // Unit components: per lane, Q = c^2 * 2^(2*UNIT_FRAC+2) / S by a row
    // of divider cells, then k = floor(sqrt(Q)) by a row of root cells.
    // The rounded unit magnitude is (k + 1) / 2. The x lane also carries
    // the zero flag and the magnitude along.
    // ------------------------------------------------------------------
    logic [QK-1:0]  wq_k   [0:2];
    logic [2:0]     wq_neg;
    logic           wq_zero;
    logic [vnm_pkg::LEN_W-1:0] wq_len;
    logic           wq_valid;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        localparam int LSB = (l == 0) ? SBX : 1;

        logic           wd_valid [0:QW];
        logic [SW-1:0]  wd_dvs   [0:QW];
        logic [SW-1:0]  wd_rem   [0:QW];
        logic           wd_nbit  [0:QW];
        logic [QW-1:0]  wd_quo   [0:QW];
        logic [LSB-1:0] wd_sb    [0:QW];

        logic           wr_valid [0:QK];
        logic [QNW-1:0] wr_rad   [0:QK];
        logic [QK+1:0]  wr_rem   [0:QK];
        logic [QK-1:0]  wr_root  [0:QK];
        logic [LSB-1:0] wr_sb    [0:QK];

        // The dividend's bits above the quotient range give c^2 / 2, which
        // is below S, so the division starts there.
        assign wd_valid[0] = rl_valid;
        assign wd_dvs[0]   = rl_s;
        assign wd_rem[0]   = SW'(rl_sq[l] >> 1);
        assign wd_nbit[0]  = rl_sq[l][0];
        assign wd_quo[0]   = '0;
        if (l == 0) begin : g_sbx
            assign wd_sb[0] = {rl_neg[l], rl_zero, rl_len};
        end else begin : g_sbn
            assign wd_sb[0] = rl_neg[l];
        end

        for (genvar g = 0; g < QW; g++) begin : g_div
            vnm_div_cell #(.DW(SW), .QW(QW), .SBW(LSB)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (wd_valid[g]),
                .i_dvs   (wd_dvs[g]),
                .i_rem   (wd_rem[g]),
                .i_nbit  (wd_nbit[g]),
                .i_quo   (wd_quo[g]),
                .i_sb    (wd_sb[g]),
                .o_valid (wd_valid[g+1]),
                .o_dvs   (wd_dvs[g+1]),
                .o_rem   (wd_rem[g+1]),
                .o_nbit  (wd_nbit[g+1]),
                .o_quo   (wd_quo[g+1]),
                .o_sb    (wd_sb[g+1])
            );
        end

        assign wr_valid[0] = wd_valid[QW];
        assign wr_rad[0]   = QNW'(wd_quo[QW]);
        assign wr_rem[0]   = '0;
        assign wr_root[0]  = '0;
        assign wr_sb[0]    = wd_sb[QW];

        for (genvar g = 0; g < QK; g++) begin : g_root
            vnm_sqrt_cell #(.NW(QNW), .SBW(LSB)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (wr_valid[g]),
                .i_rad   (wr_rad[g]),
                .i_rem   (wr_rem[g]),
                .i_root  (wr_root[g]),
                .i_sb    (wr_sb[g]),
                .o_valid (wr_valid[g+1]),
                .o_rad   (wr_rad[g+1]),
                .o_rem   (wr_rem[g+1]),
                .o_root  (wr_root[g+1]),
                .o_sb    (wr_sb[g+1])
            );
        end

        assign wq_k[l] = wr_root[QK];
        if (l == 0) begin : g_outx
            assign {wq_neg[l], wq_zero, wq_len} = wr_sb[QK];
            assign wq_valid = wr_valid[QK];
        end else begin : g_outn
            assign wq_neg[l] = wr_sb[QK];
        end
    end

    // ------------------------------------------------------------------
    // Final stage: round, apply signs, handle the zero vector.
    // ------------------------------------------------------------------
    logic [QK:0]               wf_n [0:2];
    logic [FW-1:0]             wf_u [0:2];
    logic [FW-1:0]             nf_unit [0:2];
    logic [vnm_pkg::LEN_W-1:0] nf_len;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wf_n[i] = ((QK+1)'(wq_k[i]) + (QK+1)'(1)) >> 1;
            wf_u[i] = FW'(wf_n[i]);
            nf_unit[i] = wq_neg[i] ? (~wf_u[i] + FW'(1)) : wf_u[i];
        end
        nf_len = wq_len;
        if (wq_zero) begin
            nf_unit[0] = FW'(1) << vnm_pkg::UNIT_FRAC;
            nf_unit[1] = '0;
            nf_unit[2] = '0;
            nf_len     = vnm_pkg::LEN_W'(1) << vnm_pkg::FRACTION_BITS;
        end
    end

    logic [FW-1:0]             r_o_unit [0:2];
    logic [vnm_pkg::LEN_W-1:0] r_o_len;
    logic                      r_o_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= wq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_unit <= nf_unit;
            r_o_len  <= nf_len;
            r_o_zero <= wq_zero;
        end
    end

    assign o_res.valid    = r_o_valid;
    assign o_res.unit_x   = $signed(r_o_unit[0]);
    assign o_res.unit_y   = $signed(r_o_unit[1]);
    assign o_res.unit_z   = $signed(r_o_unit[2]);
    assign o_res.length   = r_o_len;
    assign o_res.was_zero = r_o_zero;
endmodule
